// File: rtl/keyed_xor_stream_scrambler_top_assert.svh
// Assertion macros for the keyed XOR stream scrambler.
// Every check samples on the rising edge of clk and is off while arst_n is low.
`ifndef KEYED_XOR_STREAM_SCRAMBLER_TOP_ASSERT_SVH
`define KEYED_XOR_STREAM_SCRAMBLER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KXS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KXS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/kxs_pkg.sv
`timescale 1ns / 1ps

package kxs_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GROUP_MAX      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_LENGTH = 2'd3;

	// Default number of key bytes; the legal range is 1 to 16
	localparam int MAX_KEY_BYTES_DEF = 8;

	// Seed shifts wrap at this span
	localparam int SHIFT_SPAN = 59;
	localparam int SHIFT_W    = 6;

	// Seed term counter; the longest seed sum has 70 terms (key length 14)
	localparam int TERM_W = 7;

endpackage

// File: rtl/keyed_xor_stream_scrambler_top.sv
`timescale 1ns / 1ps
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+--------------------------------
// input     | in        | in_valid / in_stall     | in_byte[7:0]
// output    | out       | out_valid / out_stall   | out_byte[7:0], checksum[15:0], last
// config    | in        | cfg_we (no wait)        | cfg_index[1:0], cfg_data[63:0]
//
// One byte per cycle sustained while out_stall is low and no seed pass runs; a result passes
// through the input register, then the result register, before it turns valid.
// The rolling-key seed is built by a one-term-per-cycle adder pass after reset and after
// every configuration write. in_stall stays high during that pass.
// A stalled result holds in the result register while the input register still takes
// one more byte; outside the seed pass, in_stall rises only when both are full and out_stall is high.
module keyed_xor_stream_scrambler_top
	import kxs_pkg::*;
#(
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            in_byte,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_byte,
	output logic [15:0]           checksum,
	output logic                  last
);

	// Key length needs to hold MAX_KEY_BYTES; key index holds 0 .. MAX_KEY_BYTES-1
	localparam int KL_W   = $clog2(MAX_KEY_BYTES + 1);
	localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int KLG_W  = KL_W + 8;

	typedef enum logic [1:0] {
		SD_PROD,   // key length times group size
		SD_INIT,   // message length times that product
		SD_SUM,    // one shifted key byte a cycle
		SD_DONE
	} seed_state_t;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [63:0] key_bytes_q;
	logic [3:0]  key_len_q;
	logic [7:0]  group_max_q;
	logic [31:0] message_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bytes_q      <= '0;
			key_len_q        <= 4'd1;
			group_max_q      <= 8'd1;
			message_length_q <= 32'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_BYTES:      key_bytes_q      <= cfg_data;
				REG_KEY_LEN:        key_len_q        <= cfg_data[3:0];
				REG_GROUP_MAX:      group_max_q      <= cfg_data[7:0];
				REG_MESSAGE_LENGTH: message_length_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Effective key length: zero counts as one, clamp to MAX_KEY_BYTES
	logic [4:0]      kl_wide;
	logic [KL_W-1:0] kl;
	logic [7:0]      grp;

	always_comb begin
		if (key_len_q == 4'd0) begin
			kl_wide = 5'd1;
		end else if ({1'b0, key_len_q} > 5'(MAX_KEY_BYTES)) begin
			kl_wide = 5'(MAX_KEY_BYTES);
		end else begin
			kl_wide = {1'b0, key_len_q};
		end
		kl  = kl_wide[KL_W-1:0];
		grp = (group_max_q == 8'd0) ? 8'd1 : group_max_q;
	end

	// Key byte lookup: a shift of 64 or more (index 8 and up) reads as zero
	function automatic logic [7:0] key_byte(input logic [KIDX_W-1:0] idx,
		input logic [63:0] keys);
		logic [63:0] sh;
		sh = keys >> {idx, 3'b000};
		return sh[7:0];
	endfunction

	// ------------------------------------------------------------------
	// Seed unit: seed = ml*kl*g mod 2^32 + sum of key[i mod kl] << (i mod 59)
	// over the smallest multiple of kl above 59 terms.
	// ------------------------------------------------------------------
	seed_state_t         sd_state;
	logic [KLG_W-1:0]    klg_q;
	logic [63:0]         seed_q;
	logic [TERM_W-1:0]   term_q;
	logic [SHIFT_W-1:0]  shift_q;
	logic [KIDX_W-1:0]   sd_kidx_q;

	logic [31:0]         seed_prod;
	logic [63:0]         seed_term;
	logic [KL_W-1:0]     sd_kidx_inc;
	logic                sd_last_term;

	assign seed_prod    = message_length_q * 32'(klg_q);
	assign seed_term    = 64'(key_byte(sd_kidx_q, key_bytes_q)) << shift_q;
	assign sd_kidx_inc  = KL_W'(sd_kidx_q) + KL_W'(1);
	assign sd_last_term = (term_q >= TERM_W'(SHIFT_SPAN + 1)) && (sd_kidx_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_state  <= SD_PROD;
			klg_q     <= '0;
			seed_q    <= '0;
			term_q    <= '0;
			shift_q   <= '0;
			sd_kidx_q <= '0;
		end else if (cfg_we) begin
			// restart the pass on any write
			sd_state <= SD_PROD;
		end else begin
			unique case (sd_state)
				SD_PROD: begin
					klg_q    <= KLG_W'(kl) * KLG_W'(grp);
					sd_state <= SD_INIT;
				end
				SD_INIT: begin
					seed_q    <= {32'd0, seed_prod};
					term_q    <= '0;
					shift_q   <= '0;
					sd_kidx_q <= '0;
					sd_state  <= SD_SUM;
				end
				SD_SUM: begin
					if (sd_last_term) begin
						sd_state <= SD_DONE;
					end else begin
						seed_q    <= seed_q + seed_term;
						term_q    <= term_q + TERM_W'(1);
						shift_q   <= (shift_q == SHIFT_W'(SHIFT_SPAN - 1)) ? '0
							: shift_q + SHIFT_W'(1);
						sd_kidx_q <= (sd_kidx_inc == kl) ? '0 : KIDX_W'(sd_kidx_inc);
					end
				end
				SD_DONE: ;
				default: sd_state <= SD_PROD;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input register
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] in_byte_s1;
	logic       adv_s1;
	logic       in_take;

	assign adv_s1   = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = (sd_state != SD_DONE) || (valid_s1 && !adv_s1);
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			in_byte_s1 <= in_byte;
		end
	end

	// ------------------------------------------------------------------
	// Message state and per-byte datapath
	// ------------------------------------------------------------------
	logic [31:0]       byte_position_q;
	logic [7:0]        run_length_now_q;
	logic [7:0]        run_count_q;
	logic [KIDX_W-1:0] key_index_q;
	logic [63:0]       rolling_key_q;
	logic [15:0]       running_sum_q;

	logic [63:0]       rk_in;
	logic [63:0]       rk_rot;
	logic [32:0]       pos_inc;
	logic [7:0]        res_byte;
	logic [15:0]       res_sum;
	logic [7:0]        rc_inc;
	logic              run_end;
	logic [KL_W-1:0]   kidx_inc;
	logic              fin;

	always_comb begin
		// seed on the first byte of each message, then rotate left by one
		rk_in    = (byte_position_q == 32'd0) ? seed_q : rolling_key_q;
		rk_rot   = {rk_in[62:0], rk_in[63]};
		pos_inc  = {1'b0, byte_position_q} + 33'd1;
		res_byte = in_byte_s1 ^ key_byte(key_index_q, key_bytes_q) ^ pos_inc[7:0]
			^ rk_rot[7:0];
		res_sum  = running_sum_q + 16'(in_byte_s1) + 16'(res_byte);
		rc_inc   = run_count_q + 8'd1;
		// a run longer than the group size ends at once
		run_end  = (rc_inc >= run_length_now_q) || (run_length_now_q > grp);
		kidx_inc = KL_W'(key_index_q) + KL_W'(1);
		fin      = pos_inc >= {1'b0, message_length_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q  <= '0;
			run_length_now_q <= 8'd1;
			run_count_q      <= '0;
			key_index_q      <= '0;
			rolling_key_q    <= '0;
			running_sum_q    <= '0;
		end else if (adv_s1) begin
			if (fin) begin
				// end of message: back to the start
				byte_position_q  <= '0;
				run_length_now_q <= 8'd1;
				run_count_q      <= '0;
				key_index_q      <= '0;
				rolling_key_q    <= '0;
				running_sum_q    <= '0;
			end else begin
				byte_position_q <= pos_inc[31:0];
				rolling_key_q   <= rk_rot;
				running_sum_q   <= res_sum;
				if (run_end) begin
					run_count_q      <= '0;
					key_index_q      <= (kidx_inc == kl) ? '0 : KIDX_W'(kidx_inc);
					run_length_now_q <= (run_length_now_q >= grp) ? 8'd1
						: run_length_now_q + 8'd1;
				end else begin
					run_count_q <= rc_inc;
				end
			end
		end else if (sd_state == SD_SUM && KL_W'(key_index_q) >= kl) begin
			// a shorter key came in mid-message: fold the index back below it
			key_index_q <= KIDX_W'(KL_W'(key_index_q) - kl);
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [15:0] checksum_q;
	logic       last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_byte_q <= res_byte;
			checksum_q <= res_sum;
			last_q     <= fin;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign checksum  = checksum_q;
	assign last      = last_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`include "keyed_xor_stream_scrambler_top_assert.svh"

	`KXS_ASSERT_NOW(a_seed_blocks_input, sd_state != SD_DONE, in_stall, "seed pass open")
	`KXS_ASSERT_NOW(a_kidx_in_range, sd_state == SD_DONE, KL_W'(key_index_q) < kl, "key index")
	`KXS_ASSERT_NOW(a_run_count_in_run, 1'b1, run_count_q < run_length_now_q, "run count")
	`KXS_ASSERT_NEXT(a_last_restarts, adv_s1 && fin, byte_position_q == 32'd0 && last_q, "restart")

endmodule
